### rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 16;
  localparam int TAG_BITS    = 8;

  // widths fixed by the port fields
  localparam int ACT_W     = 3;
  localparam int ID_W      = 5;
  localparam int PERIOD_W  = 16;
  localparam int TAG_IN_W  = 8;
  localparam int TAG_OUT_W = 8;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = ((ID_W > CNT_W) ? ID_W : CNT_W) + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_START    = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_TICK     = 3'd4,
    ACT_DISPATCH = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET_RUN,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic                   running;
    logic [PERIOD_BITS-1:0] count;
    logic [PERIOD_BITS-1:0] period;
    logic [TAG_BITS-1:0]    tag;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
  } used_cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } free_t;

  typedef struct packed {
    logic                 status;
    logic [ID_W-1:0]      slot;
    logic [TAG_OUT_W-1:0] tag;
    logic                 disp;
    logic                 last;
  } result_t;

endpackage

### rtl/ptt_slot_ram.sv
module ptt_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ptt_seq.sv
module ptt_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ptt_pkg::ACT_W-1:0]           action_i,
  input  logic [ptt_pkg::ID_W-1:0]            task_id_i,
  input  logic [ptt_pkg::PERIOD_W-1:0]        period_i,
  input  logic [ptt_pkg::TAG_IN_W-1:0]        handler_tag_i,
  input  logic [ptt_pkg::NUM_SLOTS-1:0]       used_i,
  input  ptt_pkg::free_t                      free_i,
  output ptt_pkg::used_cmd_t                  used_cmd_o,
  output logic                                ram_we_o,
  output logic [ptt_pkg::IDX_W-1:0]           ram_waddr_o,
  output logic [ptt_pkg::ENTRY_W-1:0]         ram_wdata_o,
  output logic                                ram_re_o,
  output logic [ptt_pkg::IDX_W-1:0]           ram_raddr_o,
  input  logic [ptt_pkg::ENTRY_W-1:0]         ram_rdata_i,
  output logic                                res_valid_o,
  output ptt_pkg::result_t                    res_o
);

  localparam int IDX_W = ptt_pkg::IDX_W;
  localparam int CNT_W = ptt_pkg::CNT_W;
  localparam int CMP_W = ptt_pkg::CMP_W;
  localparam int PB    = ptt_pkg::PERIOD_BITS;

  ptt_pkg::state_e    state_q, state_d;
  ptt_pkg::action_e   act_q, act_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               vld_q;
  logic [IDX_W-1:0]   pidx_q;
  logic [IDX_W-1:0]   sidx_q, sidx_d;
  logic               pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic [ptt_pkg::TAG_BITS-1:0] pend_tag_q, pend_tag_d;
  logic               res_vld_q, res_vld_d;
  ptt_pkg::result_t   res_q, res_d;

  ptt_pkg::slot_entry_t rd_entry, wr_entry;
  logic [CMP_W-1:0]   id_m1;
  logic [IDX_W-1:0]   id_idx;
  logic               id_ok;
  logic               scan_more;
  logic [PB-1:0]      count_inc;

  assign rd_entry  = ram_rdata_i;
  assign id_m1     = CMP_W'(task_id_i) - CMP_W'(1);
  assign id_idx    = id_m1[IDX_W-1:0];
  assign id_ok     = (task_id_i != '0) && (CMP_W'(task_id_i) <= CMP_W'(ptt_pkg::NUM_SLOTS))
                     && used_i[id_idx];
  assign scan_more = (cnt_q < CNT_W'(ptt_pkg::NUM_SLOTS));
  assign count_inc = rd_entry.count + PB'(1);
  assign busy      = (state_q != ptt_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cnt_d       = cnt_q;
    sidx_d      = sidx_q;
    pend_vld_d  = pend_vld_q;
    pend_idx_d  = pend_idx_q;
    pend_tag_d  = pend_tag_q;
    used_cmd_o  = '0;
    ram_we_o    = 1'b0;
    ram_waddr_o = pidx_q;
    wr_entry    = rd_entry;
    ram_re_o    = 1'b0;
    ram_raddr_o = cnt_q[IDX_W-1:0];
    res_vld_d   = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;

    unique case (state_q)
      ptt_pkg::ST_IDLE: begin
        if (start) begin
          res_vld_d = 1'b1;
          unique case (action_i)
            ptt_pkg::ACT_CREATE: begin
              res_d.status = !free_i.found;
              if (free_i.found) begin
                used_cmd_o.set   = 1'b1;
                used_cmd_o.idx   = free_i.idx;
                ram_we_o         = 1'b1;
                ram_waddr_o      = free_i.idx;
                wr_entry.running = 1'b0;
                wr_entry.count   = '0;
                wr_entry.period  = PB'(period_i);
                wr_entry.tag     = ptt_pkg::TAG_BITS'(handler_tag_i);
                res_d.slot       = ptt_pkg::ID_W'(CNT_W'(free_i.idx) + CNT_W'(1));
              end
            end
            ptt_pkg::ACT_DELETE: begin
              res_d.status   = !id_ok;
              used_cmd_o.clr = id_ok;
              used_cmd_o.idx = id_idx;
            end
            ptt_pkg::ACT_START, ptt_pkg::ACT_STOP: begin
              if (id_ok) begin
                // read the entry now, write the run flag back next cycle
                res_vld_d   = 1'b0;
                ram_re_o    = 1'b1;
                ram_raddr_o = id_idx;
                sidx_d      = id_idx;
                act_d       = ptt_pkg::action_e'(action_i);
                state_d     = ptt_pkg::ST_SET_RUN;
              end else begin
                res_d.status = 1'b1;
              end
            end
            ptt_pkg::ACT_TICK, ptt_pkg::ACT_DISPATCH: begin
              res_vld_d  = 1'b0;
              cnt_d      = '0;
              pend_vld_d = 1'b0;
              act_d      = ptt_pkg::action_e'(action_i);
              state_d    = ptt_pkg::ST_SCAN;
            end
            default: begin
              res_d.status = 1'b1;
            end
          endcase
        end
      end

      ptt_pkg::ST_SET_RUN: begin
        ram_we_o         = 1'b1;
        ram_waddr_o      = sidx_q;
        wr_entry.running = (act_q == ptt_pkg::ACT_START);
        res_vld_d        = 1'b1;
        state_d          = ptt_pkg::ST_IDLE;
      end

      ptt_pkg::ST_SCAN: begin
        if (scan_more) begin
          ram_re_o = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
        end
        if (vld_q && used_i[pidx_q]) begin
          if (act_q == ptt_pkg::ACT_TICK) begin
            if (!rd_entry.running) begin
              ram_we_o = 1'b1;
              if (count_inc >= rd_entry.period) begin
                wr_entry.count   = '0;
                wr_entry.running = 1'b1;
              end else begin
                wr_entry.count = count_inc;
              end
            end
          end else if (rd_entry.running) begin
            // hold one hit back so the final beat can carry last
            if (pend_vld_q) begin
              res_vld_d  = 1'b1;
              res_d.slot = ptt_pkg::ID_W'(CNT_W'(pend_idx_q) + CNT_W'(1));
              res_d.tag  = ptt_pkg::TAG_OUT_W'(pend_tag_q);
              res_d.disp = 1'b1;
              res_d.last = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_idx_d = pidx_q;
            pend_tag_d = rd_entry.tag;
            if (rd_entry.period != '0) begin
              ram_we_o         = 1'b1;
              wr_entry.running = 1'b0;
            end
          end
        end
        if (!scan_more && !vld_q) begin
          res_vld_d = 1'b1;
          if (act_q == ptt_pkg::ACT_DISPATCH && pend_vld_q) begin
            res_d.slot = ptt_pkg::ID_W'(CNT_W'(pend_idx_q) + CNT_W'(1));
            res_d.tag  = ptt_pkg::TAG_OUT_W'(pend_tag_q);
            res_d.disp = 1'b1;
          end
          state_d = ptt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  assign ram_wdata_o = wr_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ptt_pkg::ST_IDLE;
      act_q      <= ptt_pkg::ACT_CREATE;
      cnt_q      <= '0;
      vld_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      act_q      <= act_d;
      cnt_q      <= cnt_d;
      vld_q      <= (state_q == ptt_pkg::ST_SCAN) && scan_more;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= cnt_q[IDX_W-1:0];
    sidx_q     <= sidx_d;
    pend_idx_q <= pend_idx_d;
    pend_tag_q <= pend_tag_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

### rtl/periodic_task_timer_table.sv
// Table of periodic task slots with ids 1 to NUM_SLOTS, driven by one command beat at a time.
// A command is taken when start is high and busy is low. Create, delete and an unknown action
// finish from the idle state; start and stop on a live slot also pass through a write-back state,
// since the slot entry is read from the slot RAM and written back. Tick and dispatch walk the
// slot RAM one slot per cycle through its single read port. Every result beat sits on the result
// ports for one cycle, marked by result_valid_o, in the cycle after the work that made it; the
// receiver cannot stall, so it must take every beat. A dispatch emits one beat per running
// slot in ascending id order, with gaps where slots are not running, or one beat with no slot
// if none runs, and flags the final beat with last_o; every other command gives one beat with
// last_o set. The next command can be given in the cycle a result is shown.
module periodic_task_timer_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ptt_pkg::ACT_W-1:0]      action_i,
  input  logic [ptt_pkg::ID_W-1:0]       task_id_i,
  input  logic [ptt_pkg::PERIOD_W-1:0]   period_i,
  input  logic [ptt_pkg::TAG_IN_W-1:0]   handler_tag_i,
  output logic                           result_valid_o,
  output logic                           status_o,
  output logic [ptt_pkg::ID_W-1:0]       slot_out_o,
  output logic [ptt_pkg::TAG_OUT_W-1:0]  tag_out_o,
  output logic                           is_dispatch_o,
  output logic                           last_o
);

  localparam int N = ptt_pkg::NUM_SLOTS;

  logic [N-1:0]                    used_q, used_d;
  ptt_pkg::free_t                  free;
  ptt_pkg::used_cmd_t              used_cmd;
  logic                            ram_we;
  logic [ptt_pkg::IDX_W-1:0]       ram_waddr;
  logic [ptt_pkg::ENTRY_W-1:0]     ram_wdata;
  logic                            ram_re;
  logic [ptt_pkg::IDX_W-1:0]       ram_raddr;
  logic [ptt_pkg::ENTRY_W-1:0]     ram_rdata;
  ptt_pkg::result_t                res;

  // lowest free slot
  always_comb begin
    free = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free.found = 1'b1;
        free.idx   = ptt_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (used_cmd.set) begin
      used_d[used_cmd.idx] = 1'b1;
    end
    if (used_cmd.clr) begin
      used_d[used_cmd.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  ptt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .task_id_i     (task_id_i),
    .period_i      (period_i),
    .handler_tag_i (handler_tag_i),
    .used_i        (used_q),
    .free_i        (free),
    .used_cmd_o    (used_cmd),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (result_valid_o),
    .res_o         (res)
  );

  ptt_slot_ram #(
    .DEPTH (N),
    .WIDTH (ptt_pkg::ENTRY_W),
    .AW    (ptt_pkg::IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o      = res.status;
  assign slot_out_o    = res.slot;
  assign tag_out_o     = res.tag;
  assign is_dispatch_o = res.disp;
  assign last_o        = res.last;

endmodule

### rtl/ptt_checker.sv
module ptt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [ptt_pkg::ACT_W-1:0]     action_i,
  input logic                          result_valid_o,
  input logic                          status_o,
  input logic [ptt_pkg::ID_W-1:0]      slot_out_o,
  input logic                          is_dispatch_o,
  input logic                          last_o
);

  // create and delete answer in the very next cycle
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (action_i == ptt_pkg::ACT_CREATE || action_i == ptt_pkg::ACT_DELETE)
    |=> result_valid_o)
    else $error("create or delete gave no result in the next cycle");

  // a beat that is not the last one means the block is still scanning
  a_more_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final beat while idle");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !is_dispatch_o |-> last_o)
    else $error("non-dispatch beat without last");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> !is_dispatch_o && slot_out_o == '0)
    else $error("error beat carries a slot");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .slot_out_o     (slot_out_o),
  .is_dispatch_o  (is_dispatch_o),
  .last_o         (last_o)
);
